### hdl/kw1281_block_link_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the block link checker
// ----------------------------------------------------------------------------
`ifndef KW1281_BLOCK_LINK_UNIT_DEFINES_SVH
`define KW1281_BLOCK_LINK_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define KW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/kw1281_pkg.sv
// ----------------------------------------------------------------------------
// kw1281_pkg
// Types, codes and helpers for the KW1281 block link engine.
// ----------------------------------------------------------------------------
package kw1281_pkg;

    typedef enum logic [2:0] {
        OP_LINE    = 3'd0,
        OP_SEND    = 3'd1,
        OP_TICK    = 3'd2,
        OP_CONNECT = 3'd3,
        OP_RECV    = 3'd4,
        OP_DROP    = 3'd5,
        OP_NONE    = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC = 3'd1,
        PH_RX   = 3'd2,
        PH_TX   = 3'd3,
        PH_ECHO = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ECHO_BAD    = 3'd1,
        ST_COUNTER_BAD = 3'd2,
        ST_TIMEOUT     = 3'd3,
        ST_TOO_LONG    = 3'd4,
        ST_BAD_SYNC    = 3'd5,
        ST_BUSY        = 3'd6
    } status_t;

    localparam logic [1:0] CFG_FIRST_BYTE_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_BYTE_TIMEOUT       = 2'd1;
    localparam logic [1:0] CFG_MAX_BLOCK_SIZE     = 2'd2;

    localparam logic [15:0] FIRST_BYTE_TIMEOUT_RST = 16'd2000;
    localparam logic [15:0] BYTE_TIMEOUT_RST       = 16'd1000;
    localparam logic [8:0]  MAX_BLOCK_SIZE_RST     = 9'd64;

    localparam logic [1:0] SYNC_LAST_IDX = 2'd2;
    localparam logic [7:0] BYTE_INVERT   = 8'hFF;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
    } item_t;

    function automatic logic [7:0] sync_magic(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = 8'h55;
            2'd1:    m = 8'h01;
            default: m = 8'h8A;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
    endfunction

endpackage

### hdl/kw1281_front.sv
// ----------------------------------------------------------------------------
// kw1281_front
// Input stage: takes items, decodes the mode into an operation, holds one.
// ----------------------------------------------------------------------------
module kw1281_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic [7:0]         s_data,
    input  logic               s_last,
    output logic               push_valid,
    input  logic               push_ready,
    output kw1281_pkg::item_t  push_item
);

    logic              valid_reg, valid_next;
    kw1281_pkg::item_t item_reg, item_next;
    kw1281_pkg::op_t   op_dec;

    always_comb begin
        unique case (s_mode)
            3'd0:    op_dec = kw1281_pkg::OP_LINE;
            3'd1:    op_dec = kw1281_pkg::OP_SEND;
            3'd2:    op_dec = kw1281_pkg::OP_TICK;
            3'd3:    op_dec = kw1281_pkg::OP_CONNECT;
            3'd4:    op_dec = kw1281_pkg::OP_RECV;
            3'd5:    op_dec = kw1281_pkg::OP_DROP;
            default: op_dec = kw1281_pkg::OP_NONE;
        endcase
    end

    assign s_ready = !valid_reg || push_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            item_next  = '{op: op_dec, data: s_data, last: s_last};
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

### hdl/kw1281_queue.sv
// ----------------------------------------------------------------------------
// kw1281_queue
// Short FIFO of decoded items between the front and back parts.
// ----------------------------------------------------------------------------
module kw1281_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  kw1281_pkg::item_t  push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output kw1281_pkg::item_t  pop_item
);

    kw1281_pkg::item_t                 mem [kw1281_pkg::Q_DEPTH];
    logic [kw1281_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [kw1281_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [kw1281_pkg::Q_CNT_W-1:0]    count_reg, count_next;
    logic                              do_push, do_pop;

    localparam logic [kw1281_pkg::Q_PTR_W-1:0] PTR_LAST =
        kw1281_pkg::Q_PTR_W'(kw1281_pkg::Q_DEPTH - 1);
    localparam logic [kw1281_pkg::Q_CNT_W-1:0] CNT_FULL =
        kw1281_pkg::Q_CNT_W'(kw1281_pkg::Q_DEPTH);

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/kw1281_back.sv
// ----------------------------------------------------------------------------
// kw1281_back
// Link state machine: executes one item per cycle, unless stalled, into the result register.
// ----------------------------------------------------------------------------
module kw1281_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  kw1281_pkg::item_t  pop_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_tx_valid,
    output logic [7:0]         m_tx_byte,
    output logic               m_rx_valid,
    output logic [7:0]         m_rx_byte,
    output logic               m_rx_last,
    output logic [2:0]         m_status,
    output logic [7:0]         m_counter_now,
    output logic               m_link_state,
    output logic [15:0]        m_data_errors,
    output logic [15:0]        m_timeout_errors
);

    // configuration
    logic [15:0] first_to_reg, byte_to_reg;
    logic [8:0]  max_size_reg;

    // link state
    kw1281_pkg::phase_t phase_reg, phase_next;
    logic [8:0]  byte_index_reg, byte_index_next;
    logic [8:0]  exp_len_reg, exp_len_next;
    logic [7:0]  echo_exp_reg, echo_exp_next;
    logic        sync_match_reg, sync_match_next;
    logic [7:0]  block_count_reg, block_count_next;
    logic        link_up_reg, link_up_next;
    logic [15:0] wait_timer_reg, wait_timer_next;
    logic        first_wait_reg, first_wait_next;
    logic [15:0] data_err_reg, data_err_next;
    logic [15:0] timeout_err_reg, timeout_err_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        rx_valid_reg, rx_valid_next;
    logic [7:0]  rx_byte_reg, rx_byte_next;
    logic        rx_last_reg, rx_last_next;
    kw1281_pkg::status_t status_reg, status_next;

    logic        do_pop, waiting, sync_ok;
    logic [1:0]  sync_idx;
    logic [8:0]  rx_idx, rx_len;
    logic [15:0] timer_inc, limit;

    assign pop_ready = !out_valid_reg || m_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign waiting   = (phase_reg == kw1281_pkg::PH_SYNC) ||
                       (phase_reg == kw1281_pkg::PH_RX) ||
                       (phase_reg == kw1281_pkg::PH_ECHO);

    assign sync_idx  = (byte_index_reg < 9'd2) ? byte_index_reg[1:0]
                                               : kw1281_pkg::SYNC_LAST_IDX;
    assign sync_ok   = sync_match_reg &&
                       (pop_item.data == kw1281_pkg::sync_magic(sync_idx));
    assign rx_idx    = byte_index_reg + 9'd1;
    assign rx_len    = (rx_idx == 9'd1) ? {1'b0, pop_item.data} + 9'd1 : exp_len_reg;
    assign timer_inc = kw1281_pkg::sat_inc16(wait_timer_reg);
    assign limit     = first_wait_reg ? first_to_reg : byte_to_reg;

    always_comb begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        exp_len_next     = exp_len_reg;
        echo_exp_next    = echo_exp_reg;
        sync_match_next  = sync_match_reg;
        block_count_next = block_count_reg;
        link_up_next     = link_up_reg;
        wait_timer_next  = wait_timer_reg;
        first_wait_next  = first_wait_reg;
        data_err_next    = data_err_reg;
        timeout_err_next = timeout_err_reg;
        tx_valid_next    = 1'b0;
        tx_byte_next     = '0;
        rx_valid_next    = 1'b0;
        rx_byte_next     = '0;
        rx_last_next     = 1'b0;
        status_next      = kw1281_pkg::ST_OK;

        if (do_pop) begin
            unique case (pop_item.op)
                kw1281_pkg::OP_LINE: begin
                    priority case (phase_reg)
                        kw1281_pkg::PH_SYNC: begin
                            sync_match_next = sync_ok;
                            byte_index_next = {7'b0, sync_idx} + 9'd1;
                            rx_valid_next   = 1'b1;
                            rx_byte_next    = pop_item.data;
                            wait_timer_next = '0;
                            first_wait_next = 1'b0;
                            if (sync_idx == kw1281_pkg::SYNC_LAST_IDX) begin
                                rx_last_next     = 1'b1;
                                tx_valid_next    = 1'b1;
                                tx_byte_next     = pop_item.data ^ kw1281_pkg::BYTE_INVERT;
                                block_count_next = block_count_reg + 8'd1;
                                phase_next       = kw1281_pkg::PH_IDLE;
                                if (sync_ok) begin
                                    link_up_next = 1'b1;
                                end else begin
                                    status_next   = kw1281_pkg::ST_BAD_SYNC;
                                    data_err_next = kw1281_pkg::sat_inc16(data_err_reg);
                                    link_up_next  = 1'b0;
                                end
                            end
                        end
                        kw1281_pkg::PH_RX: begin
                            byte_index_next = rx_idx;
                            exp_len_next    = rx_len;
                            wait_timer_next = '0;
                            first_wait_next = 1'b0;
                            if (rx_idx == 9'd1 && rx_len > max_size_reg) begin
                                status_next = kw1281_pkg::ST_TOO_LONG;
                                phase_next  = kw1281_pkg::PH_IDLE;
                            end else if (rx_idx == 9'd2 && pop_item.data != block_count_reg) begin
                                status_next   = kw1281_pkg::ST_COUNTER_BAD;
                                data_err_next = kw1281_pkg::sat_inc16(data_err_reg);
                                link_up_next  = 1'b0;
                                phase_next    = kw1281_pkg::PH_IDLE;
                            end else begin
                                rx_valid_next = 1'b1;
                                rx_byte_next  = pop_item.data;
                                if (rx_idx < rx_len) begin
                                    tx_valid_next = 1'b1;
                                    tx_byte_next  = pop_item.data ^ kw1281_pkg::BYTE_INVERT;
                                end else begin
                                    rx_last_next     = 1'b1;
                                    block_count_next = block_count_reg + 8'd1;
                                    phase_next       = kw1281_pkg::PH_IDLE;
                                end
                            end
                        end
                        kw1281_pkg::PH_ECHO: begin
                            if (pop_item.data == echo_exp_reg) begin
                                phase_next = kw1281_pkg::PH_TX;
                            end else begin
                                status_next   = kw1281_pkg::ST_ECHO_BAD;
                                data_err_next = kw1281_pkg::sat_inc16(data_err_reg);
                                link_up_next  = 1'b0;
                                phase_next    = kw1281_pkg::PH_IDLE;
                            end
                        end
                        default: begin
                            // stray byte in idle or between send bytes
                        end
                    endcase
                end
                kw1281_pkg::OP_SEND: begin
                    if (waiting) begin
                        status_next = kw1281_pkg::ST_BUSY;
                    end else begin
                        tx_valid_next = 1'b1;
                        tx_byte_next  = pop_item.data;
                        if (pop_item.last) begin
                            block_count_next = block_count_reg + 8'd1;
                            phase_next       = kw1281_pkg::PH_IDLE;
                        end else begin
                            echo_exp_next   = pop_item.data ^ kw1281_pkg::BYTE_INVERT;
                            phase_next      = kw1281_pkg::PH_ECHO;
                            wait_timer_next = '0;
                            first_wait_next = 1'b0;
                        end
                    end
                end
                kw1281_pkg::OP_TICK: begin
                    if (waiting) begin
                        wait_timer_next = timer_inc;
                        if (timer_inc >= limit) begin
                            status_next      = kw1281_pkg::ST_TIMEOUT;
                            timeout_err_next = kw1281_pkg::sat_inc16(timeout_err_reg);
                            link_up_next     = 1'b0;
                            phase_next       = kw1281_pkg::PH_IDLE;
                        end
                    end
                end
                kw1281_pkg::OP_CONNECT: begin
                    block_count_next = '0;
                    link_up_next     = 1'b0;
                    phase_next       = kw1281_pkg::PH_SYNC;
                    byte_index_next  = '0;
                    sync_match_next  = 1'b1;
                    wait_timer_next  = '0;
                    first_wait_next  = 1'b1;
                end
                kw1281_pkg::OP_RECV: begin
                    if (phase_reg != kw1281_pkg::PH_IDLE) begin
                        status_next = kw1281_pkg::ST_BUSY;
                    end else begin
                        phase_next      = kw1281_pkg::PH_RX;
                        byte_index_next = '0;
                        exp_len_next    = '0;
                        wait_timer_next = '0;
                        first_wait_next = 1'b1;
                    end
                end
                kw1281_pkg::OP_DROP: begin
                    link_up_next = 1'b0;
                    phase_next   = kw1281_pkg::PH_IDLE;
                end
                default: begin
                    // unused modes
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (do_pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_to_reg    <= kw1281_pkg::FIRST_BYTE_TIMEOUT_RST;
            byte_to_reg     <= kw1281_pkg::BYTE_TIMEOUT_RST;
            max_size_reg    <= kw1281_pkg::MAX_BLOCK_SIZE_RST;
            phase_reg       <= kw1281_pkg::PH_IDLE;
            byte_index_reg  <= '0;
            exp_len_reg     <= '0;
            echo_exp_reg    <= '0;
            sync_match_reg  <= 1'b1;
            block_count_reg <= '0;
            link_up_reg     <= 1'b0;
            wait_timer_reg  <= '0;
            first_wait_reg  <= 1'b0;
            data_err_reg    <= '0;
            timeout_err_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    kw1281_pkg::CFG_FIRST_BYTE_TIMEOUT: first_to_reg <= cfg_data;
                    kw1281_pkg::CFG_BYTE_TIMEOUT:       byte_to_reg  <= cfg_data;
                    kw1281_pkg::CFG_MAX_BLOCK_SIZE:     max_size_reg <= cfg_data[8:0];
                    default: begin
                        // index beyond the register list: ignored
                    end
                endcase
            end
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            exp_len_reg     <= exp_len_next;
            echo_exp_reg    <= echo_exp_next;
            sync_match_reg  <= sync_match_next;
            block_count_reg <= block_count_next;
            link_up_reg     <= link_up_next;
            wait_timer_reg  <= wait_timer_next;
            first_wait_reg  <= first_wait_next;
            data_err_reg    <= data_err_next;
            timeout_err_reg <= timeout_err_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload, loaded with each executed item
    always_ff @(posedge aclk) begin
        if (do_pop) begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            rx_valid_reg <= rx_valid_next;
            rx_byte_reg  <= rx_byte_next;
            rx_last_reg  <= rx_last_next;
            status_reg   <= status_next;
        end
    end

    // state outputs follow the state registers, which move only on a pop
    assign m_valid          = out_valid_reg;
    assign m_tx_valid       = tx_valid_reg;
    assign m_tx_byte        = tx_byte_reg;
    assign m_rx_valid       = rx_valid_reg;
    assign m_rx_byte        = rx_byte_reg;
    assign m_rx_last        = rx_last_reg;
    assign m_status         = status_reg;
    assign m_counter_now    = block_count_reg;
    assign m_link_state     = link_up_reg;
    assign m_data_errors    = data_err_reg;
    assign m_timeout_errors = timeout_err_reg;

endmodule

### hdl/kw1281_block_link_unit.sv
// ----------------------------------------------------------------------------
// kw1281_block_link_unit
// Byte-level KW1281 link engine: sync, block receive and block send.
// ----------------------------------------------------------------------------
// Input channel s_*: one event per item (mode, data, last): line byte, host
// send byte, tick, connect, receive block or drop link.
// Result channel m_*: exactly one result item per input item, in order,
// giving the byte to transmit, the byte delivered to the host, a status
// code, the block counter, the link state and the two error counts.
// Configuration: cfg_we/cfg_index/cfg_data write the timeouts and the
// maximum block size; write them only while idle.
// Throughput is one item per cycle while the receiver takes results; the
// link state machine in the back part updates once per item. An accepted
// item passes the input register, the item queue and the result register.
// When the receiver stalls the result register holds, the queue and input
// register fill, and s_ready falls after at most three more items.
// Reset (aresetn low, synchronous) empties the pipeline, restores the
// register defaults and leaves the link down in idle.
// ----------------------------------------------------------------------------
module kw1281_block_link_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_data,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_byte,
    output logic        m_rx_last,
    output logic [2:0]  m_status,
    output logic [7:0]  m_counter_now,
    output logic        m_link_state,
    output logic [15:0] m_data_errors,
    output logic [15:0] m_timeout_errors
);

    logic              push_valid, push_ready;
    kw1281_pkg::item_t push_item;
    logic              pop_valid, pop_ready;
    kw1281_pkg::item_t pop_item;

    kw1281_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_data     (s_data),
        .s_last     (s_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    kw1281_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    kw1281_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tx_valid       (m_tx_valid),
        .m_tx_byte        (m_tx_byte),
        .m_rx_valid       (m_rx_valid),
        .m_rx_byte        (m_rx_byte),
        .m_rx_last        (m_rx_last),
        .m_status         (m_status),
        .m_counter_now    (m_counter_now),
        .m_link_state     (m_link_state),
        .m_data_errors    (m_data_errors),
        .m_timeout_errors (m_timeout_errors)
    );

endmodule

### hdl/kw1281_checker.sv
// ----------------------------------------------------------------------------
// kw1281_checker
// Port-level checks for the block link engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "kw1281_block_link_unit_defines.svh"

module kw1281_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_tx_valid,
    input logic [7:0]  m_tx_byte,
    input logic        m_rx_valid,
    input logic [7:0]  m_rx_byte,
    input logic        m_rx_last,
    input logic [2:0]  m_status,
    input logic        m_link_state
);

    logic err_status;

    // every error outcome except an over-long block or a busy refusal takes the link down
    assign err_status = (m_status == kw1281_pkg::ST_ECHO_BAD) ||
                        (m_status == kw1281_pkg::ST_COUNTER_BAD) ||
                        (m_status == kw1281_pkg::ST_TIMEOUT) ||
                        (m_status == kw1281_pkg::ST_BAD_SYNC);

    `KW_ASSERT_NOW(a_tx_quiet, aclk, aresetn, m_valid && !m_tx_valid, m_tx_byte == 8'h00, "tx byte set without tx_valid")
    `KW_ASSERT_NOW(a_rx_quiet, aclk, aresetn, m_valid && !m_rx_valid, (m_rx_byte == 8'h00) && !m_rx_last, "rx fields set without rx_valid")
    `KW_ASSERT_NOW(a_err_link, aclk, aresetn, m_valid && err_status, !m_link_state, "link still up after a link error")
    `KW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_tx_byte) && $stable(m_rx_byte), "stalled result changed")

endmodule

bind kw1281_block_link_unit kw1281_checker u_checker (.*);
